[design/icbc_pkg.sv]
package icbc_pkg;

  localparam int IDX_W    = 36;  // linear cell index
  localparam int N_COEF   = 8;   // coefficient slots per beat
  localparam int INT_BITS = 4;   // integer bits of the fixed-point format
  localparam int CNT_W    = 4;
  localparam int CFG_W    = 2;

  typedef enum logic [1:0] {
    OP_SINGLE = 2'd0,
    OP_QUAD   = 2'd1,
    OP_OCTET  = 2'd2,
    OP_OTHER  = 2'd3
  } op_t;

  // register indexes of the configuration port
  localparam logic [CFG_W-1:0] CFG_CELLS_I = 2'd0;
  localparam logic [CFG_W-1:0] CFG_CELLS_J = 2'd1;
  localparam logic [CFG_W-1:0] CFG_CELLS_K = 2'd2;

  // coefficient counts per kind
  localparam logic [CNT_W-1:0] CNT_NONE   = 4'd0;
  localparam logic [CNT_W-1:0] CNT_SINGLE = 4'd1;
  localparam logic [CNT_W-1:0] CNT_QUAD   = 4'd4;
  localparam logic [CNT_W-1:0] CNT_OCTET  = 4'd8;

  typedef struct packed {
    op_t  op;
    logic last;
  } item_ctl_t;

  // band: imin, imax, jmin, jmax (bit 0 up)
  // corner: (2,2), (2,nj-2), (ni-2,2), (ni-2,nj-2) (bit 0 up)
  typedef struct packed {
    logic [3:0] corner;
    logic [3:0] band;
  } quad_flags_t;

endpackage

[design/icbc_in_if.sv]
interface icbc_in_if #(parameter int COEF_W = 32);
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic [35:0]              point_index;
  logic signed [COEF_W-1:0] coef_in_0;
  logic signed [COEF_W-1:0] coef_in_1;
  logic signed [COEF_W-1:0] coef_in_2;
  logic signed [COEF_W-1:0] coef_in_3;
  logic signed [COEF_W-1:0] coef_in_4;
  logic signed [COEF_W-1:0] coef_in_5;
  logic signed [COEF_W-1:0] coef_in_6;
  logic signed [COEF_W-1:0] coef_in_7;
  logic                     last_point;

  modport source (output valid, operation, point_index, coef_in_0, coef_in_1, coef_in_2,
                  coef_in_3, coef_in_4, coef_in_5, coef_in_6, coef_in_7, last_point,
                  input ready);
  modport sink (input valid, operation, point_index, coef_in_0, coef_in_1, coef_in_2,
                coef_in_3, coef_in_4, coef_in_5, coef_in_6, coef_in_7, last_point,
                output ready);
endinterface

[design/icbc_out_if.sv]
interface icbc_out_if #(parameter int COEF_W = 32);
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coef_out_0;
  logic signed [COEF_W-1:0] coef_out_1;
  logic signed [COEF_W-1:0] coef_out_2;
  logic signed [COEF_W-1:0] coef_out_3;
  logic signed [COEF_W-1:0] coef_out_4;
  logic signed [COEF_W-1:0] coef_out_5;
  logic signed [COEF_W-1:0] coef_out_6;
  logic signed [COEF_W-1:0] coef_out_7;
  logic [3:0]               coef_count;
  logic                     last_out;

  modport source (output valid, coef_out_0, coef_out_1, coef_out_2, coef_out_3, coef_out_4,
                  coef_out_5, coef_out_6, coef_out_7, coef_count, last_out,
                  input ready);
  modport sink (input valid, coef_out_0, coef_out_1, coef_out_2, coef_out_3, coef_out_4,
                coef_out_5, coef_out_6, coef_out_7, coef_count, last_out,
                output ready);
endinterface

[design/interp_coeff_border_correct.sv]
// Channel  Dir  Beat contents                                         Handshake
// in_bus   in   operation, point_index, coef_in_0..7, last_point      valid/ready
// out_bus  out  coef_out_0..7, coef_count, last_out                   valid/ready
// cfg_*    in   cfg_index selects cells_i/j/k, cfg_wr_data            cfg_wr_en
//
// One beat per cycle sustained while the output is ready. Pipeline: input register,
// 36-stage index / (ni*nj) divider, 2*DIM_WIDTH-stage remainder / ni divider,
// then the correction pipeline.
// rst_n is synchronous, active low; it clears valid bits and sets cells_* to 1.
// Every stage holds its beat while the next one is full and stalled, so bubbles
// collapse and the input keeps taking beats while a result waits at the output.
module interp_coeff_border_correct import icbc_pkg::*; #(
  parameter int COEF_WIDTH = 32,
  parameter int DIM_WIDTH  = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  icbc_in_if.sink              in_bus,
  icbc_out_if.source           out_bus,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_index,
  input  logic [DIM_WIDTH-1:0] cfg_wr_data
);

  localparam int PLANE_W = 2 * DIM_WIDTH;
  localparam int SIDE1_W = 3 + N_COEF * COEF_WIDTH;   // op, last, coefficients
  localparam int SIDE2_W = IDX_W + SIDE1_W;           // plus k-1

  // ---- configuration
  logic [DIM_WIDTH-1:0] cells_i_r, cells_j_r, cells_k_r;
  logic [DIM_WIDTH-1:0] ni_eff, nj_eff, nk_eff;
  logic [PLANE_W-1:0]   plane_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_i_r <= DIM_WIDTH'(1);
      cells_j_r <= DIM_WIDTH'(1);
      cells_k_r <= DIM_WIDTH'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_CELLS_I: cells_i_r <= cfg_wr_data;
        CFG_CELLS_J: cells_j_r <= cfg_wr_data;
        CFG_CELLS_K: cells_k_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // a zero count acts as one
  assign ni_eff = (cells_i_r == '0) ? DIM_WIDTH'(1) : cells_i_r;
  assign nj_eff = (cells_j_r == '0) ? DIM_WIDTH'(1) : cells_j_r;
  assign nk_eff = (cells_k_r == '0) ? DIM_WIDTH'(1) : cells_k_r;

  // plane size, registered from the effective cell counts
  always_ff @(posedge clk) begin
    plane_r <= PLANE_W'(ni_eff) * PLANE_W'(nj_eff);
  end

  // ---- input register
  logic                 in_v_r;
  logic [IDX_W-1:0]     idx_r;
  logic [SIDE1_W-1:0]   side_in_r;
  logic                 d1_rdy;

  assign in_bus.ready = !in_v_r || d1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready) begin
      idx_r     <= in_bus.point_index;
      side_in_r <= {in_bus.operation, in_bus.last_point,
                    in_bus.coef_in_7, in_bus.coef_in_6, in_bus.coef_in_5, in_bus.coef_in_4,
                    in_bus.coef_in_3, in_bus.coef_in_2, in_bus.coef_in_1, in_bus.coef_in_0};
    end
  end

  // ---- k-1 = idx / plane, rem = idx mod plane
  logic                 d1_vld, d2_rdy;
  logic [IDX_W-1:0]     q1;
  logic [PLANE_W-1:0]   rem1;
  logic [SIDE1_W-1:0]   side1;

  icbc_div #(.NUM_W(IDX_W), .DEN_W(PLANE_W), .SIDE_W(SIDE1_W)) u_div_plane (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_v_r),
    .in_rdy   (d1_rdy),
    .in_num   (idx_r),
    .in_side  (side_in_r),
    .den      (plane_r),
    .out_vld  (d1_vld),
    .out_rdy  (d2_rdy),
    .out_quo  (q1),
    .out_rem  (rem1),
    .out_side (side1)
  );

  // ---- j-1 = rem / ni, i-1 = rem mod ni
  logic                 d2_vld, fx_rdy;
  logic [PLANE_W-1:0]   q2;
  logic [DIM_WIDTH-1:0] rem2;
  logic [SIDE2_W-1:0]   side2;

  icbc_div #(.NUM_W(PLANE_W), .DEN_W(DIM_WIDTH), .SIDE_W(SIDE2_W)) u_div_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (d1_vld),
    .in_rdy   (d2_rdy),
    .in_num   (rem1),
    .in_side  ({q1, side1}),
    .den      (ni_eff),
    .out_vld  (d2_vld),
    .out_rdy  (fx_rdy),
    .out_quo  (q2),
    .out_rem  (rem2),
    .out_side (side2)
  );

  // ---- unpack and correct
  item_ctl_t                    ctl;
  logic signed [COEF_WIDTH-1:0] coef_arr [N_COEF];
  logic signed [COEF_WIDTH-1:0] coef_res [N_COEF];

  assign ctl.op   = op_t'(side2[SIDE1_W-1 -: 2]);
  assign ctl.last = side2[N_COEF*COEF_WIDTH];

  for (genvar z = 0; z < N_COEF; z++) begin : g_unpack
    assign coef_arr[z] = side2[z*COEF_WIDTH +: COEF_WIDTH];
  end

  // quotient q2 is below nj, so its low DIM_WIDTH bits carry j-1
  icbc_fix #(.COEF_W(COEF_WIDTH), .DIM_W(DIM_WIDTH)) u_fix (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (d2_vld),
    .in_rdy     (fx_rdy),
    .in_ctl     (ctl),
    .i0         (rem2),
    .j0         (q2[DIM_WIDTH-1:0]),
    .k0         (side2[SIDE2_W-1 -: IDX_W]),
    .ni         (ni_eff),
    .nj         (nj_eff),
    .nk         (nk_eff),
    .coef_in    (coef_arr),
    .out_vld    (out_bus.valid),
    .out_rdy    (out_bus.ready),
    .coef_out   (coef_res),
    .coef_count (out_bus.coef_count),
    .last_out   (out_bus.last_out)
  );

  assign out_bus.coef_out_0 = coef_res[0];
  assign out_bus.coef_out_1 = coef_res[1];
  assign out_bus.coef_out_2 = coef_res[2];
  assign out_bus.coef_out_3 = coef_res[3];
  assign out_bus.coef_out_4 = coef_res[4];
  assign out_bus.coef_out_5 = coef_res[5];
  assign out_bus.coef_out_6 = coef_res[6];
  assign out_bus.coef_out_7 = coef_res[7];

  // ---- checks
  // a free output frees every stage back to the input
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.ready |-> in_bus.ready)
    else $error("input stalled while output is ready");

  a_count_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (out_bus.coef_count == CNT_NONE || out_bus.coef_count == CNT_SINGLE ||
                       out_bus.coef_count == CNT_QUAD || out_bus.coef_count == CNT_OCTET))
    else $error("bad coefficient count");

  a_quad_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.coef_count == CNT_QUAD) |->
      (out_bus.coef_out_4 == '0 && out_bus.coef_out_5 == '0 &&
       out_bus.coef_out_6 == '0 && out_bus.coef_out_7 == '0))
    else $error("quad result has nonzero upper coefficients");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.coef_count == CNT_NONE) |->
      (out_bus.coef_out_0 == '0 && out_bus.coef_out_1 == '0))
    else $error("empty result carries coefficients");

endmodule

[design/icbc_div.sv]
// Restoring divider, one quotient bit per stage, elastic valid/ready chain.
module icbc_div #(
  parameter int NUM_W  = 36,
  parameter int DEN_W  = 24,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_rdy,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [SIDE_W-1:0] in_side,
  input  logic [DEN_W-1:0]  den,
  output logic              out_vld,
  input  logic              out_rdy,
  output logic [NUM_W-1:0]  out_quo,
  output logic [DEN_W-1:0]  out_rem,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r  [NUM_W];
  logic [NUM_W-1:0]  num_r  [NUM_W];
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];
  logic [NUM_W:0]    rdy;

  assign rdy[NUM_W] = out_rdy;
  assign in_rdy     = rdy[0];

  for (genvar s = 0; s < NUM_W; s++) begin : g_st
    logic              v_s;
    logic [NUM_W-1:0]  num_s;
    logic [DEN_W-1:0]  rem_s;
    logic [SIDE_W-1:0] side_s;
    logic [DEN_W:0]    acc;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign v_s    = in_vld;
      assign num_s  = in_num;
      assign rem_s  = '0;
      assign side_s = in_side;
    end else begin : g_next
      assign v_s    = vld_r[s-1];
      assign num_s  = num_r[s-1];
      assign rem_s  = rem_r[s-1];
      assign side_s = side_r[s-1];
    end

    // numerator shifts out at the top while quotient bits shift in at the bottom
    assign acc    = {rem_s, num_s[NUM_W-1]};
    assign diff   = acc - {1'b0, den};
    assign ge     = (acc >= {1'b0, den});
    assign rdy[s] = !vld_r[s] || rdy[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_r[s] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        rem_r[s]  <= ge ? diff[DEN_W-1:0] : acc[DEN_W-1:0];
        num_r[s]  <= {num_s[NUM_W-2:0], ge};
        side_r[s] <= side_s;
      end
    end
  end

  assign out_vld  = vld_r[NUM_W-1];
  assign out_quo  = num_r[NUM_W-1];
  assign out_rem  = rem_r[NUM_W-1];
  assign out_side = side_r[NUM_W-1];

endmodule

[design/icbc_fix.sv]
// Coefficient correction pipeline: flags, quad bands, corners,
// divide-by-valid-count, signed quotient, octet redistribution, final select.
module icbc_fix import icbc_pkg::*; #(
  parameter int COEF_W = 32,
  parameter int DIM_W  = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  output logic                     in_rdy,
  input  item_ctl_t                in_ctl,
  input  logic [DIM_W-1:0]         i0,
  input  logic [DIM_W-1:0]         j0,
  input  logic [IDX_W-1:0]         k0,
  input  logic [DIM_W-1:0]         ni,
  input  logic [DIM_W-1:0]         nj,
  input  logic [DIM_W-1:0]         nk,
  input  logic signed [COEF_W-1:0] coef_in [N_COEF],
  output logic                     out_vld,
  input  logic                     out_rdy,
  output logic signed [COEF_W-1:0] coef_out [N_COEF],
  output logic [CNT_W-1:0]         coef_count,
  output logic                     last_out
);

  localparam int STEPS     = 4;                      // quotient bits per divide stage
  localparam int NST       = (COEF_W + STEPS - 1) / STEPS;
  localparam int NP        = NST * STEPS;
  localparam int RM_W      = 4;
  localparam int CMP_W     = IDX_W + 2;
  localparam int ST_QUAD   = 1;                      // four band stages
  localparam int ST_CORNER = ST_QUAD + 4;
  localparam int ST_DIV    = ST_CORNER + 1;
  localparam int ST_SGN    = ST_DIV + NST;
  localparam int ST_ACC    = ST_SGN + 1;             // four stages, two cubes each
  localparam int ST_FIN    = ST_ACC + 4;
  localparam int NS        = ST_FIN + 1;

  localparam logic signed [COEF_W-1:0] ONE_FX =
    {{(INT_BITS-1){1'b0}}, 1'b1, {(COEF_W-INT_BITS){1'b0}}};
  localparam logic signed [COEF_W-1:0] MAX_FX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] MIN_FX = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [CMP_W-1:0]  TWO    = CMP_W'(2);
  localparam logic signed [CMP_W-1:0]  THREE  = CMP_W'(3);

  // band b: average of (SA,SB) is added to (DA,DB), sources cleared
  localparam int BAND_SA [4] = '{0, 1, 0, 2};
  localparam int BAND_SB [4] = '{2, 3, 1, 3};
  localparam int BAND_DA [4] = '{1, 0, 2, 0};
  localparam int BAND_DB [4] = '{3, 2, 3, 1};

  function automatic logic signed [COEF_W-1:0] sat_add(input logic signed [COEF_W-1:0] a,
                                                       input logic signed [COEF_W-1:0] b);
    logic signed [COEF_W:0] sm;
    sm = {a[COEF_W-1], a} + {b[COEF_W-1], b};
    if (sm[COEF_W] != sm[COEF_W-1]) begin
      return sm[COEF_W] ? MIN_FX : MAX_FX;
    end
    return sm[COEF_W-1:0];
  endfunction

  // ---- coordinates and flags (in front of stage 0)
  logic signed [CMP_W-1:0] ci, cj, ck, cni, cnj, cnk;
  logic                    imid, jmid;
  logic [1:0]              oki, okj, okk;
  logic [N_COEF-1:0]       ok_in, neg_in;
  quad_flags_t             fl_in;
  logic [NP-1:0]           mag_in [N_COEF];

  assign ci  = $signed(CMP_W'(i0)) + CMP_W'(1);
  assign cj  = $signed(CMP_W'(j0)) + CMP_W'(1);
  assign ck  = $signed(CMP_W'(k0)) + CMP_W'(1);
  assign cni = $signed(CMP_W'(ni));
  assign cnj = $signed(CMP_W'(nj));
  assign cnk = $signed(CMP_W'(nk));

  assign imid = (ci > TWO) && (ci < cni - TWO);
  assign jmid = (cj > TWO) && (cj < cnj - TWO);

  assign fl_in.band[0]   = (ci == TWO) && jmid;
  assign fl_in.band[1]   = (ci == cni - TWO) && jmid;
  assign fl_in.band[2]   = (cj == TWO) && imid;
  assign fl_in.band[3]   = (cj == cnj - TWO) && imid;
  assign fl_in.corner[0] = (ci == TWO) && (cj == TWO);
  assign fl_in.corner[1] = (ci == TWO) && (cj == cnj - TWO);
  assign fl_in.corner[2] = (ci == cni - TWO) && (cj == TWO);
  assign fl_in.corner[3] = (ci == cni - TWO) && (cj == cnj - TWO);

  for (genvar d = 0; d < 2; d++) begin : g_axis
    assign oki[d] = (ci + CMP_W'(d) >= THREE) && (ci + CMP_W'(d) <= cni - TWO);
    assign okj[d] = (cj + CMP_W'(d) >= THREE) && (cj + CMP_W'(d) <= cnj - TWO);
    assign okk[d] = (ck + CMP_W'(d) >= THREE) && (ck + CMP_W'(d) <= cnk - TWO);
  end

  for (genvar z = 0; z < N_COEF; z++) begin : g_cube
    logic [COEF_W-1:0] a;
    assign ok_in[z]  = oki[z % 2] & okj[(z / 2) % 2] & okk[z / 4];
    assign neg_in[z] = coef_in[z][COEF_W-1];
    assign a         = neg_in[z] ? (~coef_in[z] + COEF_W'(1)) : coef_in[z];
    assign mag_in[z] = NP'(a);
  end

  // ---- stage registers
  logic                     vld_r  [NS];
  op_t                      op_r   [NS];
  logic                     last_r [NS];
  logic signed [COEF_W-1:0] c_r    [NS][N_COEF];
  logic [NP-1:0]            m_r    [NS][N_COEF];
  logic [RM_W-1:0]          rm_r   [NS][N_COEF];
  logic [N_COEF-1:0]        neg_r  [NS];
  logic [N_COEF-1:0]        ok_r   [NS];
  logic [CNT_W-1:0]         n_r    [NS];
  quad_flags_t              fl_r   [NS];
  logic [NS:0]              rdy;

  assign rdy[NS] = out_rdy;
  assign in_rdy  = rdy[0];

  for (genvar s = 0; s < NS; s++) begin : g_st
    localparam int BI = (s >= ST_QUAD && s < ST_CORNER) ? s - ST_QUAD : 0;
    localparam int AI = (s >= ST_ACC && s < ST_FIN) ? s - ST_ACC : 0;

    logic                     v_s, last_s;
    op_t                      op_s;
    logic signed [COEF_W-1:0] c_s [N_COEF];
    logic [NP-1:0]            m_s [N_COEF];
    logic [RM_W-1:0]          rm_s [N_COEF];
    logic [N_COEF-1:0]        neg_s, ok_s;
    logic [CNT_W-1:0]         n_s;
    quad_flags_t              fl_s;

    logic signed [COEF_W-1:0] c_nxt [N_COEF];
    logic [NP-1:0]            m_nxt [N_COEF];
    logic [RM_W-1:0]          rm_nxt [N_COEF];
    logic [CNT_W-1:0]         n_nxt;

    if (s == 0) begin : g_first
      always_comb begin
        v_s    = in_vld;
        op_s   = in_ctl.op;
        last_s = in_ctl.last;
        c_s    = coef_in;
        m_s    = mag_in;
        for (int z = 0; z < N_COEF; z++) begin
          rm_s[z] = '0;
        end
        neg_s = neg_in;
        ok_s  = ok_in;
        n_s   = '0;
        fl_s  = fl_in;
      end
    end else begin : g_next
      always_comb begin
        v_s    = vld_r[s-1];
        op_s   = op_r[s-1];
        last_s = last_r[s-1];
        c_s    = c_r[s-1];
        m_s    = m_r[s-1];
        rm_s   = rm_r[s-1];
        neg_s  = neg_r[s-1];
        ok_s   = ok_r[s-1];
        n_s    = n_r[s-1];
        fl_s   = fl_r[s-1];
      end
    end

    always_comb begin
      logic signed [COEF_W:0]   sm;
      logic signed [COEF_W-1:0] h;
      logic [RM_W:0]            dacc;
      logic [RM_W-1:0]          r;
      logic [NP-1:0]            m;
      logic                     q;
      logic                     oct_act;
      int                       pos;
      int                       bb;

      c_nxt  = c_s;
      m_nxt  = m_s;
      rm_nxt = rm_s;
      n_nxt  = n_s;
      sm     = '0;
      h      = '0;
      dacc   = '0;
      r      = '0;
      m      = '0;
      q      = 1'b0;
      pos    = 0;
      bb     = 0;
      oct_act = (op_s == OP_OCTET) && (n_s != CNT_NONE) && (n_s != CNT_OCTET);

      // valid cube count
      if (s == ST_QUAD) begin
        n_nxt = '0;
        for (int z = 0; z < N_COEF; z++) begin
          n_nxt = n_nxt + CNT_W'(ok_s[z]);
        end
      end

      // one quad band per stage, in rule order
      if (s >= ST_QUAD && s < ST_CORNER) begin
        if (op_s == OP_QUAD && fl_s.band[BI]) begin
          sm = {c_s[BAND_SA[BI]][COEF_W-1], c_s[BAND_SA[BI]]}
             + {c_s[BAND_SB[BI]][COEF_W-1], c_s[BAND_SB[BI]]};
          h  = sm[COEF_W:1];
          c_nxt[BAND_DA[BI]] = sat_add(c_s[BAND_DA[BI]], h);
          c_nxt[BAND_DB[BI]] = sat_add(c_s[BAND_DB[BI]], h);
          c_nxt[BAND_SA[BI]] = '0;
          c_nxt[BAND_SB[BI]] = '0;
        end
      end

      // corners: last match wins
      if (s == ST_CORNER) begin
        if (op_s == OP_QUAD && (fl_s.corner != 4'b0000)) begin
          priority if (fl_s.corner[3]) pos = 0;
          else if (fl_s.corner[2]) pos = 2;
          else if (fl_s.corner[1]) pos = 1;
          else pos = 3;
          for (int z = 0; z < 4; z++) begin
            c_nxt[z] = (z == pos) ? ONE_FX : '0;
          end
        end
      end

      // magnitude / valid count, STEPS bits per stage
      if (s >= ST_DIV && s < ST_SGN) begin
        for (int z = 0; z < N_COEF; z++) begin
          r = rm_s[z];
          m = m_s[z];
          for (int t = 0; t < STEPS; t++) begin
            dacc = {r, m[NP-1]};
            q    = (dacc >= {1'b0, n_s});
            r    = q ? RM_W'(dacc - {1'b0, n_s}) : dacc[RM_W-1:0];
            m    = {m[NP-2:0], q};
          end
          rm_nxt[z] = r;
          m_nxt[z]  = m;
        end
      end

      // truncate toward zero: restore sign
      if (s == ST_SGN) begin
        for (int z = 0; z < N_COEF; z++) begin
          m_nxt[z] = NP'(neg_s[z] ? (~m_s[z][COEF_W-1:0] + COEF_W'(1))
                                  : m_s[z][COEF_W-1:0]);
        end
      end

      // invalid cubes 2*AI and 2*AI+1 feed every valid cube
      if (s >= ST_ACC && s < ST_FIN) begin
        for (int u = 0; u < 2; u++) begin
          bb = 2 * AI + u;
          if (oct_act && !ok_s[bb]) begin
            for (int z = 0; z < N_COEF; z++) begin
              if (ok_s[z]) begin
                c_nxt[z] = sat_add(c_nxt[z], $signed(m_s[bb][COEF_W-1:0]));
              end
            end
          end
        end
      end

      // final select; n carries the coefficient count from here on
      if (s == ST_FIN) begin
        if (oct_act) begin
          for (int z = 0; z < N_COEF; z++) begin
            if (!ok_s[z]) c_nxt[z] = '0;
          end
        end
        unique case (op_s)
          OP_SINGLE: begin
            n_nxt = CNT_SINGLE;
            for (int z = 1; z < N_COEF; z++) c_nxt[z] = '0;
          end
          OP_QUAD: begin
            n_nxt = CNT_QUAD;
            for (int z = 4; z < N_COEF; z++) c_nxt[z] = '0;
          end
          OP_OCTET: begin
            n_nxt = CNT_OCTET;
          end
          default: begin
            n_nxt = CNT_NONE;
            for (int z = 0; z < N_COEF; z++) c_nxt[z] = '0;
          end
        endcase
      end
    end

    assign rdy[s] = !vld_r[s] || rdy[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_r[s] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        op_r[s]   <= op_s;
        last_r[s] <= last_s;
        c_r[s]    <= c_nxt;
        m_r[s]    <= m_nxt;
        rm_r[s]   <= rm_nxt;
        neg_r[s]  <= neg_s;
        ok_r[s]   <= ok_s;
        n_r[s]    <= n_nxt;
        fl_r[s]   <= fl_s;
      end
    end
  end

  assign out_vld    = vld_r[NS-1];
  assign coef_out   = c_r[NS-1];
  assign coef_count = n_r[NS-1];
  assign last_out   = last_r[NS-1];

endmodule

[bench/icbc_checker.sv]
`timescale 1ns / 1ps
module icbc_checker import icbc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  icbc_in_if      in_bus,
  icbc_out_if     out_bus,
  input  logic    cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_index,
  input  logic [11:0] cfg_wr_data,
  output int      fail_count,
  output int      pending_count
);
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam longint ONE_Q = 64'sd1 << 28;

  typedef struct {
    logic [31:0] coef [8];
    logic [3:0]  count;
    logic        last;
  } coef_result_t;

  coef_result_t expected_q [$];
  logic [11:0] dim_i, dim_j, dim_k;

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > CMAX) return CMAX;
    if (s < CMIN) return CMIN;
    return s;
  endfunction

  function automatic longint avg_down(longint a, longint b);
    longint s;
    s = a + b;
    return (s - (s & 1)) / 2;
  endfunction

  function automatic bit axis_valid(longint p, longint n);
    return p >= 3 && p <= n - 2;
  endfunction

  function automatic coef_result_t correct_point(logic [1:0] op, logic [35:0] idx,
                                                 logic [31:0] cin [8], logic last);
    coef_result_t r;
    longint c [8];
    longint ni, nj, nk, i, j, k, h, n;
    longint unsigned plane, rem;
    bit ok [8];
    bit jmid, imid;
    ni = (dim_i == 0) ? 1 : dim_i;
    nj = (dim_j == 0) ? 1 : dim_j;
    nk = (dim_k == 0) ? 1 : dim_k;
    plane = ni * nj;
    rem = idx % plane;
    k = idx / plane + 1;
    j = rem / ni + 1;
    i = rem % ni + 1;
    for (int z = 0; z < 8; z++) c[z] = longint'(signed'(cin[z]));
    case (op_t'(op))
      OP_SINGLE: r.count = CNT_SINGLE;
      OP_QUAD: begin
        r.count = CNT_QUAD;
        jmid = j > 2 && j < nj - 2;
        imid = i > 2 && i < ni - 2;
        if (i == 2 && jmid) begin
          h = avg_down(c[0], c[2]);
          c[1] = sat_sum(c[1], h); c[3] = sat_sum(c[3], h); c[0] = 0; c[2] = 0;
        end
        if (i == ni - 2 && jmid) begin
          h = avg_down(c[1], c[3]);
          c[0] = sat_sum(c[0], h); c[2] = sat_sum(c[2], h); c[1] = 0; c[3] = 0;
        end
        if (j == 2 && imid) begin
          h = avg_down(c[0], c[1]);
          c[2] = sat_sum(c[2], h); c[3] = sat_sum(c[3], h); c[0] = 0; c[1] = 0;
        end
        if (j == nj - 2 && imid) begin
          h = avg_down(c[2], c[3]);
          c[0] = sat_sum(c[0], h); c[1] = sat_sum(c[1], h); c[2] = 0; c[3] = 0;
        end
        // corners: last match wins
        for (int q = 0; q < 4; q++) begin
          if ((q[1] ? i == ni - 2 : i == 2) && (q[0] ? j == nj - 2 : j == 2)) begin
            for (int z = 0; z < 4; z++) c[z] = 0;
            c[q[0] ? (q[1] ? 0 : 1) : (q[1] ? 2 : 3)] = ONE_Q;
          end
        end
      end
      OP_OCTET: begin
        r.count = CNT_OCTET;
        n = 0;
        for (int z = 0; z < 8; z++) begin
          ok[z] = axis_valid(i + z[0], ni) && axis_valid(j + z[1], nj)
               && axis_valid(k + z[2], nk);
          if (ok[z]) n++;
        end
        if (n != 0 && n != 8) begin
          for (int b = 0; b < 8; b++) begin
            if (!ok[b]) begin
              for (int z = 0; z < 8; z++) if (ok[z]) c[z] = sat_sum(c[z], c[b] / n);
              c[b] = 0;
            end
          end
        end
      end
      default: r.count = CNT_NONE;
    endcase
    for (int z = 0; z < 8; z++) r.coef[z] = (z < r.count) ? c[z][31:0] : '0;
    r.last = last;
    return r;
  endfunction

  always @(posedge clk) begin
    logic [31:0] cin [8];
    logic [31:0] got [8];
    coef_result_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      dim_i <= 1; dim_j <= 1; dim_k <= 1;
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CELLS_I: dim_i <= cfg_wr_data;
          CFG_CELLS_J: dim_j <= cfg_wr_data;
          CFG_CELLS_K: dim_k <= cfg_wr_data;
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        cin = '{in_bus.coef_in_0, in_bus.coef_in_1, in_bus.coef_in_2, in_bus.coef_in_3,
                in_bus.coef_in_4, in_bus.coef_in_5, in_bus.coef_in_6, in_bus.coef_in_7};
        expected_q.push_back(correct_point(in_bus.operation, in_bus.point_index, cin,
                                           in_bus.last_point));
      end
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.coef_out_0, out_bus.coef_out_1, out_bus.coef_out_2,
                out_bus.coef_out_3, out_bus.coef_out_4, out_bus.coef_out_5,
                out_bus.coef_out_6, out_bus.coef_out_7};
        if (expected_q.size() == 0) begin
          $error("unexpected result beat");
          errs++;
        end else begin
          e = expected_q.pop_front();
          for (int z = 0; z < 8; z++) begin
            if (got[z] !== e.coef[z]) begin
              $error("coef_out_%0d: expected %h, got %h", z, e.coef[z], got[z]);
              errs++;
            end
          end
          if (out_bus.coef_count !== e.count) begin
            $error("coef_count: expected %0d, got %0d", e.count, out_bus.coef_count);
            errs++;
          end
          if (out_bus.last_out !== e.last) begin
            $error("last_out: expected %0d, got %0d", e.last, out_bus.last_out);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending_count <= expected_q.size();
  end
endmodule

[bench/interp_coeff_border_correct_test.sv]
`timescale 1ns / 1ps
module interp_coeff_border_correct_test import icbc_pkg::*;;
  // Pipeline is 81 deep at default widths; drain waits allow for more.
  localparam int PIPE_DEPTH = 81;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_index = CFG_CELLS_I;
  logic [11:0] cfg_wr_data = '0;
  int fail_count, pending_count;

  // idle and stall rates for the sender and receiver processes
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int   sent_beats = 0;

  icbc_in_if  in_bus ();
  icbc_out_if out_bus ();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  interp_coeff_border_correct u_dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  icbc_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    in_bus.valid = 1'b0;
    in_bus.operation = OP_SINGLE;
    in_bus.point_index = '0;
    in_bus.coef_in_0 = '0; in_bus.coef_in_1 = '0; in_bus.coef_in_2 = '0;
    in_bus.coef_in_3 = '0; in_bus.coef_in_4 = '0; in_bus.coef_in_5 = '0;
    in_bus.coef_in_6 = '0; in_bus.coef_in_7 = '0;
    in_bus.last_point = 1'b0;
    out_bus.ready = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off to back up the pipe.
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_bus.ready <= 1'b0;
    else out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [11:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
  endtask

  task automatic set_cells(input logic [11:0] ni, input logic [11:0] nj,
                           input logic [11:0] nk);
    write_reg(CFG_CELLS_I, ni);
    write_reg(CFG_CELLS_J, nj);
    write_reg(CFG_CELLS_K, nk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Coefficients biased toward the saturation edges and small values.
  function automatic logic [31:0] pick_coef();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff - $urandom_range(3);
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return $urandom_range(32) - 16;
      default: return $urandom;
    endcase
  endfunction

  // Sends one beat; valid stays high between back-to-back beats.
  task automatic send_point(input logic [1:0] op, input logic [35:0] idx,
                            input logic [31:0] c [8], input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.operation <= op;
    in_bus.point_index <= idx;
    in_bus.coef_in_0 <= c[0]; in_bus.coef_in_1 <= c[1];
    in_bus.coef_in_2 <= c[2]; in_bus.coef_in_3 <= c[3];
    in_bus.coef_in_4 <= c[4]; in_bus.coef_in_5 <= c[5];
    in_bus.coef_in_6 <= c[6]; in_bus.coef_in_7 <= c[7];
    in_bus.last_point <= last;
    do @(posedge clk); while (!in_bus.ready);
    sent_beats++;
  endtask

  task automatic random_coefs(output logic [31:0] c [8]);
    for (int z = 0; z < 8; z++) c[z] = pick_coef();
  endtask

  // Index aimed at the border bands: i, j, k in 1..5 or n-4..n.
  function automatic logic [35:0] near_border(int ni, int nj, int nk);
    longint i, j, k;
    i = $urandom_range(1) ? $urandom_range(4) : ni - 1 - $urandom_range(4);
    j = $urandom_range(1) ? $urandom_range(4) : nj - 1 - $urandom_range(4);
    k = $urandom_range(1) ? $urandom_range(4) : nk - 1 - $urandom_range(4);
    if (i < 0) i = 0;
    if (j < 0) j = 0;
    if (k < 0) k = 0;
    if (i >= ni) i = ni - 1;
    if (j >= nj) j = nj - 1;
    if (k >= nk) k = nk - 1;
    return 36'((k * nj + j) * ni + i);
  endfunction

  task automatic drain();
    int guard;
    in_bus.valid <= 1'b0;
    guard = 0;
    while (pending_count != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (PIPE_DEPTH + 20) @(posedge clk);
  endtask

  // Random phase on the given grid; mostly band-aimed points.
  task automatic random_phase(input int ni, input int nj, input int nk, input int beats);
    logic [31:0] c [8];
    logic [35:0] idx;
    for (int b = 0; b < beats; b++) begin
      random_coefs(c);
      if ($urandom_range(3) != 0) idx = near_border(ni, nj, nk);
      else idx = 36'({$urandom, $urandom});
      send_point(2'($urandom_range(3)), idx, c, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [31:0] c [8];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset grid (1x1x1), all kinds, field extremes.
    c = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
          32'h1, 32'h7fff_ffff, 32'h8000_0000, 32'h5555_5555};
    send_point(OP_SINGLE, 36'h0, c, 1'b0);
    send_point(OP_QUAD, 36'hf_ffff_ffff, c, 1'b1);
    send_point(OP_OCTET, 36'h0, c, 1'b0);
    send_point(OP_OTHER, 36'hf_ffff_ffff, c, 1'b1);
    drain();

    // Directed: 10x10x10 grid, every band, corner and a mixed octet.
    set_cells(12'd10, 12'd10, 12'd10);
    c = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h8000_0000, 32'h8000_0000, 32'h0000_0003, 32'hffff_fffd};
    send_point(OP_QUAD, 36'd41, c, 1'b0);   // imin band (i=2, j=5)
    send_point(OP_QUAD, 36'd47, c, 1'b0);   // imax band (i=8, j=5)
    send_point(OP_QUAD, 36'd14, c, 1'b0);   // jmin band
    send_point(OP_QUAD, 36'd74, c, 1'b0);   // jmax band
    send_point(OP_QUAD, 36'd11, c, 1'b0);   // corner (2,2)
    send_point(OP_QUAD, 36'd71, c, 1'b0);   // corner (2,nj-2)
    send_point(OP_QUAD, 36'd17, c, 1'b0);   // corner (ni-2,2)
    send_point(OP_QUAD, 36'd77, c, 1'b0);   // corner (ni-2,nj-2)
    send_point(OP_OCTET, 36'd222, c, 1'b0); // fully valid cube
    send_point(OP_OCTET, 36'd111, c, 1'b0); // mixed validity
    send_point(OP_OCTET, 36'd666, c, 1'b1); // fully valid cube at the far side
    drain();

    // Zero register is treated as one; maximum extents too.
    set_cells(12'd0, 12'd4095, 12'd0);
    random_phase(1, 4095, 1, 10);
    drain();

    // Idle phases across several grids.
    set_cells(12'd8, 12'd7, 12'd9);
    random_phase(8, 7, 9, 125);
    drain();
    send_idle_pct = 54;
    set_cells(12'd6, 12'd6, 12'd6);
    random_phase(6, 6, 6, 100);
    drain();
    send_idle_pct = 0; recv_stall_pct = 54;
    set_cells(12'd4095, 12'd4095, 12'd4095);
    random_phase(4095, 4095, 4095, 100);
    drain();
    send_idle_pct = 11; recv_stall_pct = 11;
    set_cells(12'd5, 12'd12, 12'd3);
    random_phase(5, 12, 3, 100);
    drain();

    // Long receiver hold-off while the sender keeps pushing, to fill the pipe.
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_off = 1'b1;
    fork
      random_phase(5, 12, 3, 100);
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    drain();

    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
